// File: hw/rtl/word_dictionary_hash_probe_macros.svh
// assertion helpers for the dictionary block
`ifndef WORD_DICTIONARY_HASH_PROBE_MACROS_SVH
`define WORD_DICTIONARY_HASH_PROBE_MACROS_SVH

// condition must hold whenever out of reset
`define WDP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define WDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/wdp_pkg.sv
package wdp_pkg;
    localparam int TABLE_SIZE = 8192;
    localparam int VOCAB_MAX  = 4096;
    localparam int MAX_LEN    = 32;

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int STEP_W  = SLOT_W + 1;
    localparam int VID_W   = $clog2(VOCAB_MAX);
    localparam int CNT_W   = VID_W + 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int WB_AW   = $clog2(2 * MAX_LEN);
    localparam int WS_AW   = $clog2(VOCAB_MAX * MAX_LEN);
    localparam int WID_W   = 13;
    localparam int ST_W    = 2;

    localparam logic [WID_W-1:0] NO_ID = '1;

    localparam logic [ST_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [ST_W-1:0] ST_INSERTED  = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] hash;
        logic [LEN_W-1:0]  len;
        logic              action;
    } t_desc;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        data;
        logic              push;
        t_desc             desc;
    } t_fe_wr;
endpackage

// File: hw/rtl/word_dictionary_hash_probe.sv
// Word dictionary on an open-addressed hash table with linear probing. Each
// input beat carries one byte; the front end hashes and buffers it, so bytes
// stream at one per cycle while a buffer slot is free (two word buffers sit
// between front and back). A word's last byte yields one result beat. The
// back end reads each probed slot and, if it is taken, the stored length,
// reads and compares each byte against a stored word, and reads and writes
// each byte copied on an insert, all through registered reads of the slot,
// length and byte memories. After reset a clearing pass empties all 8192
// slots before the first word is looked up; bytes enter the buffers meanwhile.
module word_dictionary_hash_probe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [7:0]         i_char_byte,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [12:0] o_word_id,
    output logic [1:0]         o_status
);
    import wdp_pkg::*;
    `include "word_dictionary_hash_probe_macros.svh"

    t_fe_wr           fe_wr;
    t_desc            q_desc;
    logic             q_full, q_valid, pop;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       wb_byte;
    logic             in_accept;
    logic             res_has_id;

    assign in_accept  = i_in_valid && !q_full;
    assign o_in_stall = q_full;
    assign res_has_id = (o_status == ST_FOUND) || (o_status == ST_INSERTED);

    wdp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_action    (i_action),
        .i_char_byte (i_char_byte),
        .i_last      (i_last),
        .o_wr        (fe_wr)
    );

    wdp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (fe_wr),
        .i_pop     (pop),
        .i_rd_idx  (rd_idx),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_desc    (q_desc),
        .o_rd_byte (wb_byte)
    );

    wdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_desc      (q_desc),
        .i_wb_byte   (wb_byte),
        .o_rd_idx    (rd_idx),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word_id   (o_word_id),
        .o_status    (o_status)
    );

    `WDP_ASSERT_IMPL(a_id_status, i_clk, i_rst_n, o_out_valid, res_has_id == (o_word_id != NO_ID))
    `WDP_ASSERT_IMPL(a_pop_needs_word, i_clk, i_rst_n, pop, q_valid)
    `WDP_ASSERT_ALWAYS(a_no_push_when_full, i_clk, i_rst_n, !(fe_wr.push && q_full && !pop))
endmodule

// File: hw/rtl/wdp_front.sv
module wdp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_action,
    input  logic [7:0]     i_char_byte,
    input  logic           i_last,
    output wdp_pkg::t_fe_wr o_wr
);
    import wdp_pkg::*;

    logic [SLOT_W-1:0] r_hash, n_hash;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_action, n_action;
    logic              room;
    logic              act_eff;
    logic [SLOT_W+8:0] mix;

    assign room    = r_len < LEN_W'(MAX_LEN);
    assign act_eff = (r_len == '0) ? i_action : r_action;
    // h*257 + signed byte
    assign mix = {9'b0, r_hash} + {1'b0, r_hash, 8'b0}
               + {{(SLOT_W+1){i_char_byte[7]}}, i_char_byte};
    assign n_hash = room ? mix[SLOT_W-1:0] : r_hash;
    assign n_len  = room ? r_len + LEN_W'(1) : r_len;
    assign n_action = act_eff;

    always_comb begin
        o_wr.we          = i_accept && room;
        o_wr.idx         = r_len[IDX_W-1:0];
        o_wr.data        = i_char_byte;
        o_wr.push        = i_accept && i_last;
        o_wr.desc.hash   = n_hash;
        o_wr.desc.len    = n_len;
        o_wr.desc.action = act_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_len    <= '0;
            r_action <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_hash   <= '0;
                r_len    <= '0;
                r_action <= 1'b0;
            end else begin
                r_hash   <= n_hash;
                r_len    <= n_len;
                r_action <= n_action;
            end
        end
    end
endmodule

// File: hw/rtl/wdp_queue.sv
module wdp_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wdp_pkg::t_fe_wr         i_wr,
    input  logic                    i_pop,
    input  logic [wdp_pkg::IDX_W-1:0] i_rd_idx,
    output logic                    o_full,
    output logic                    o_valid,
    output wdp_pkg::t_desc          o_desc,
    output logic [7:0]              o_rd_byte
);
    import wdp_pkg::*;

    logic [7:0] r_buf [2*MAX_LEN];
    t_desc      r_desc [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic [7:0] r_rd_byte;
    logic [WB_AW-1:0] wr_addr, rd_addr;

    assign wr_addr = (r_wptr ? WB_AW'(MAX_LEN) : '0) + WB_AW'(i_wr.idx);
    assign rd_addr = (r_rptr ? WB_AW'(MAX_LEN) : '0) + WB_AW'(i_rd_idx);

    assign o_full    = r_cnt == 2'd2;
    assign o_valid   = r_cnt != 2'd0;
    assign o_desc    = r_desc[r_rptr];
    assign o_rd_byte = r_rd_byte;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_buf[wr_addr] <= i_wr.data;
        end
        r_rd_byte <= r_buf[rd_addr];
        if (i_wr.push) begin
            r_desc[r_wptr] <= i_wr.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_wr.push) - 2'(i_pop);
        end
    end
endmodule

// File: hw/rtl/wdp_back.sv
module wdp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  wdp_pkg::t_desc            i_desc,
    input  logic [7:0]                i_wb_byte,
    output logic [wdp_pkg::IDX_W-1:0] o_rd_idx,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [12:0]        o_word_id,
    output logic [1:0]                o_status
);
    import wdp_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;
    localparam logic [3:0] S_SCHK = 4'd3;
    localparam logic [3:0] S_LRD  = 4'd4;
    localparam logic [3:0] S_LCHK = 4'd5;
    localparam logic [3:0] S_CRD  = 4'd6;
    localparam logic [3:0] S_CCHK = 4'd7;
    localparam logic [3:0] S_DEC  = 4'd8;
    localparam logic [3:0] S_WRD  = 4'd9;
    localparam logic [3:0] S_WWR  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [VID_W:0]    r_slot_mem [TABLE_SIZE];
    logic [LEN_W-1:0]  r_len_mem [VOCAB_MAX];
    logic [7:0]        r_ws_mem [VOCAB_MAX*MAX_LEN];
    logic [VID_W:0]    r_slot_q;
    logic [LEN_W-1:0]  r_len_q;
    logic [7:0]        r_ws_q;

    logic [3:0]        r_state;
    logic [SLOT_W-1:0] r_pos, r_clr;
    logic [STEP_W-1:0] r_steps;
    logic [VID_W-1:0]  r_id;
    logic [LEN_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_hit, r_empty;
    logic [WID_W-1:0]  r_res_id;
    logic [ST_W-1:0]   r_res_st;
    logic              r_out_valid;
    logic [WID_W-1:0]  r_out_id;
    logic [ST_W-1:0]   r_out_st;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [VID_W:0]    slot_wdata;
    logic [WS_AW-1:0]  ws_raddr, ws_waddr;
    logic              out_free;
    logic              idx_end;

    assign slot_we    = (r_state == S_CLR) || (r_state == S_FIN);
    assign slot_waddr = (r_state == S_CLR) ? r_clr : r_pos;
    assign slot_wdata = (r_state == S_CLR) ? '0 : {1'b1, r_cnt[VID_W-1:0]};
    assign ws_raddr   = WS_AW'(WS_AW'(r_id) * WS_AW'(MAX_LEN) + WS_AW'(r_idx));
    assign ws_waddr   = WS_AW'(WS_AW'(r_cnt[VID_W-1:0]) * WS_AW'(MAX_LEN)
                      + WS_AW'(r_idx));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign idx_end    = (r_idx + LEN_W'(1)) == i_desc.len;
    assign o_rd_idx   = r_idx[IDX_W-1:0];
    assign o_pop      = (r_state == S_OUT) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_word_id  = r_out_id;
    assign o_status   = r_out_st;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= r_slot_mem[r_pos];
        if (r_state == S_FIN) begin
            r_len_mem[r_cnt[VID_W-1:0]] <= i_desc.len;
        end
        r_len_q <= r_len_mem[r_id];
        if (r_state == S_WWR) begin
            r_ws_mem[ws_waddr] <= i_wb_byte;
        end
        r_ws_q <= r_ws_mem[ws_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_steps     <= '0;
            r_id        <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_empty     <= 1'b0;
            r_res_id    <= NO_ID;
            r_res_st    <= ST_FOUND;
            r_out_valid <= 1'b0;
            r_out_id    <= NO_ID;
            r_out_st    <= ST_FOUND;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + SLOT_W'(1);
                    if (r_clr == SLOT_W'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_pos   <= i_desc.hash;
                        r_steps <= '0;
                        r_hit   <= 1'b0;
                        r_empty <= 1'b0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_steps == STEP_W'(TABLE_SIZE)) begin
                        r_state <= S_DEC;
                    end else begin
                        r_state <= S_SCHK;
                    end
                end
                S_SCHK: begin
                    if (!r_slot_q[VID_W]) begin
                        r_empty <= 1'b1;
                        r_state <= S_DEC;
                    end else begin
                        r_id    <= r_slot_q[VID_W-1:0];
                        r_state <= S_LRD;
                    end
                end
                S_LRD: begin
                    r_state <= S_LCHK;
                end
                S_LCHK: begin
                    r_idx <= '0;
                    if (r_len_q != i_desc.len) begin
                        r_pos   <= r_pos + SLOT_W'(1);
                        r_steps <= r_steps + STEP_W'(1);
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_CRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                S_CCHK: begin
                    priority if (r_ws_q != i_wb_byte) begin
                        r_pos   <= r_pos + SLOT_W'(1);
                        r_steps <= r_steps + STEP_W'(1);
                        r_state <= S_SRD;
                    end else if (idx_end) begin
                        r_hit   <= 1'b1;
                        r_state <= S_DEC;
                    end else begin
                        r_idx   <= r_idx + LEN_W'(1);
                        r_state <= S_CRD;
                    end
                end
                S_DEC: begin
                    r_idx <= '0;
                    priority if (r_hit) begin
                        r_res_id <= WID_W'(r_id);
                        r_res_st <= ST_FOUND;
                        r_state  <= S_OUT;
                    end else if (!i_desc.action) begin
                        r_res_id <= NO_ID;
                        r_res_st <= ST_NOT_FOUND;
                        r_state  <= S_OUT;
                    end else if (!r_empty || r_cnt >= CNT_W'(VOCAB_MAX)) begin
                        r_res_id <= NO_ID;
                        r_res_st <= ST_FULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_WRD;
                    end
                end
                S_WRD: begin
                    r_state <= S_WWR;
                end
                S_WWR: begin
                    if (idx_end) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + LEN_W'(1);
                        r_state <= S_WRD;
                    end
                end
                S_FIN: begin
                    r_res_id <= WID_W'(r_cnt);
                    r_res_st <= ST_INSERTED;
                    r_cnt    <= r_cnt + CNT_W'(1);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_id    <= r_res_id;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
